// File: hw/rtl/dfwa_pkg.sv
// Shared constants, types and helpers for the deduplicating write arbiter.
`timescale 1ns / 1ps

package dfwa_pkg;

   localparam int NUM_WRITERS = 8;
   localparam int ID_W        = 3;
   localparam int OP_W        = 2;

   typedef enum logic [OP_W-1:0] {
      OP_REQUEST = 2'd0,
      OP_QUERY   = 2'd1,
      OP_RELEASE = 2'd2
   } dfwa_op_type;

   // One queue slot as seen by its neighbours.
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
   } dfwa_slot_type;

   // Broadcast command to every cell.
   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] id;
   } dfwa_cmd_type;

   function automatic logic [NUM_WRITERS-1:0] dfwa_onehot(input logic [ID_W-1:0] w);
      logic [NUM_WRITERS-1:0] r;
      for (int k = 0; k < NUM_WRITERS; k++) begin
         r[k] = (32'(w) == k);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/dfwa_cell.sv
// One slot of the shifting order queue: fills from the tail, shifts towards the head on pop.
`timescale 1ns / 1ps

module dfwa_cell
   import dfwa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dfwa_cmd_type  cmd,
   input  logic          prev_valid,
   input  dfwa_slot_type next_slot,
   output dfwa_slot_type slot
);

   logic            valid_ff, valid_in;
   logic [ID_W-1:0] id_ff, id_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      if (cmd.pop) begin
         valid_in = next_slot.valid;
         id_in    = next_slot.id;
      end else if (cmd.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         id_in    = cmd.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

   assign slot.valid = valid_ff;
   assign slot.id    = id_ff;

endmodule

// File: hw/rtl/dedup_fifo_write_arbiter.sv
// Top level of the deduplicating FIFO write arbiter.
`timescale 1ns / 1ps

// Every request is accepted whenever start is high (busy stays low) and its
// result appears on the rsp_ ports, marked by rsp_valid, in the next cycle,
// for that cycle only. The queue is a row of cells with the head in cell 0;
// outside bypass mode a grant compares the head cell, a release shifts the row
// by one, and a presence bitmap suppresses duplicates.

module dedup_fifo_write_arbiter
   import dfwa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [OP_W-1:0] req_type,
   input  logic [ID_W-1:0] req_writer_id,
   output logic            rsp_valid,
   output logic            rsp_granted,
   output logic            rsp_present,
   output logic            rsp_error,
   input  logic            csr_we,
   input  logic            csr_bypass_mode
);

   dfwa_slot_type          slots [NUM_WRITERS+1];
   dfwa_cmd_type           cmd;
   logic                   bypass_ff;
   logic [NUM_WRITERS-1:0] presence_ff, presence_in;
   logic [NUM_WRITERS-1:0] id_hot;
   logic                   id_ok, hit, empty, accept;
   logic                   valid_ff, granted_ff, present_ff, error_ff;
   logic                   granted_in, present_in, error_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign id_hot = dfwa_onehot(req_writer_id);
   assign id_ok  = (32'(req_writer_id) < NUM_WRITERS);
   assign hit    = |(presence_ff & id_hot);
   assign empty  = !slots[0].valid;

   // slots[NUM_WRITERS] is the empty neighbour past the tail
   assign slots[NUM_WRITERS].valid = 1'b0;
   assign slots[NUM_WRITERS].id    = '0;

   genvar g;
   generate
      for (g = 0; g < NUM_WRITERS; g++) begin : g_cell
         logic prev_valid;
         if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_valid = slots[g-1].valid;
         end
         dfwa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_valid (prev_valid),
            .next_slot  (slots[g+1]),
            .slot       (slots[g])
         );
      end
   endgenerate

   always_comb begin
      cmd.push    = 1'b0;
      cmd.pop     = 1'b0;
      cmd.id      = req_writer_id;
      presence_in = presence_ff;
      granted_in  = 1'b0;
      present_in  = 1'b0;
      error_in    = 1'b0;
      if (accept) begin
         unique case (req_type)
            OP_REQUEST: begin
               if (bypass_ff) begin
                  granted_in = 1'b1;
               end else if (id_ok) begin
                  if (!hit) begin
                     cmd.push    = 1'b1;
                     presence_in = presence_ff | id_hot;
                  end
                  granted_in = empty ? !hit : (slots[0].id == req_writer_id);
               end
            end
            OP_QUERY: begin
               present_in = !bypass_ff && id_ok && hit;
            end
            OP_RELEASE: begin
               if (!bypass_ff) begin
                  if (empty) begin
                     error_in = 1'b1;
                  end else begin
                     cmd.pop     = 1'b1;
                     presence_in = presence_ff & ~dfwa_onehot(slots[0].id);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff   <= 1'b0;
         presence_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            bypass_ff <= csr_bypass_mode;
         end
         presence_ff <= presence_in;
         valid_ff    <= accept;
      end
      granted_ff <= granted_in;
      present_ff <= present_in;
      error_ff   <= error_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_granted = granted_ff;
   assign rsp_present = present_ff;
   assign rsp_error   = error_ff;

endmodule
